/* sv/running_mean_and_std_dev_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the running mean and deviation block
// Short forms for clocked properties that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_AND_STD_DEV_MACROS_SVH
`define RUNNING_MEAN_AND_STD_DEV_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rmsd_pkg.sv */
// ----------------------------------------------------------------------------
// Running mean and deviation package
// Operation codes, fixed datapath widths and control types shared by the
// sequencer and the iterative arithmetic unit.
// ----------------------------------------------------------------------------
package rmsd_pkg;

    localparam int DATA_W     = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 35;
    localparam int ACC_W      = 128;
    localparam int CHUNK_W    = 16;
    localparam int MUL_STEPS  = DATA_W / CHUNK_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = 7;

    localparam logic [1:0] OP_DIV  = 2'd0;
    localparam logic [1:0] OP_MUL  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    localparam logic signed [63:0] MEAN_OUT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] MEAN_OUT_MIN = -64'sd2147483648;

    typedef struct packed {
        logic              start;
        logic [1:0]        op;
        logic [STEP_W-1:0] steps;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

/* sv/rmsd_unit.sv */
// ----------------------------------------------------------------------------
// Iterative arithmetic unit
// Runs a restoring division, a digit-by-digit square root or a 64 x 64 bit
// multiplication from 64 x 16 bit partial products, one step per cycle, on one
// shared subtractor and one narrow multiplier.
// ----------------------------------------------------------------------------
module rmsd_unit
    import rmsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  unit_cmd_t         cmd,
    input  logic [DATA_W-1:0] opa,
    input  logic [DATA_W-1:0] opb,
    output logic [DATA_W-1:0] result,
    output unit_stat_t        stat
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        op_reg, op_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] oper_reg, oper_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic [REM_W-1:0]  sub_a;
    logic [REM_W-1:0]  sub_b;
    logic [REM_W:0]    sub_full;
    logic              sub_ge;
    logic [DATA_W+CHUNK_W-1:0] pprod;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            sub_a = {rem_reg[REM_W-3:0], quo_reg[DATA_W-1 -: 2]};
            sub_b = {1'b0, root_reg, 2'b01};
        end
        else
        begin
            sub_a = {rem_reg[REM_W-2:0], quo_reg[DATA_W-1]};
            sub_b = REM_W'(oper_reg[31:0]);
        end
        sub_full = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_full[REM_W];
        pprod    = oper_reg * quo_reg[DATA_W-1 -: CHUNK_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        oper_next = oper_reg;
        root_next = root_reg;
        acc_next  = acc_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            rem_next  = '0;
            root_next = '0;
            acc_next  = '0;
            case (cmd.op)
                OP_MUL:
                begin
                    cnt_next  = STEP_W'(MUL_STEPS);
                    quo_next  = opb;
                    oper_next = opa;
                end
                OP_SQRT:
                begin
                    cnt_next  = STEP_W'(SQRT_STEPS);
                    quo_next  = opa;
                    oper_next = opb;
                end
                default:
                begin
                    cnt_next  = cmd.steps;
                    quo_next  = opa;
                    oper_next = opb;
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            case (op_reg)
                OP_MUL:
                begin
                    acc_next = {acc_reg[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                             + ACC_W'(pprod);
                    quo_next = {quo_reg[DATA_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
                end
                OP_SQRT:
                begin
                    rem_next  = sub_ge ? sub_full[REM_W-1:0] : sub_a;
                    root_next = {root_reg[ROOT_W-2:0], sub_ge};
                    quo_next  = {quo_reg[DATA_W-3:0], 2'b00};
                end
                default:
                begin
                    rem_next = sub_ge ? sub_full[REM_W-1:0] : sub_a;
                    quo_next = {quo_reg[DATA_W-2:0], sub_ge};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        oper_reg <= oper_next;
        root_reg <= root_next;
        acc_reg  <= acc_next;
    end

    // A product keeps its bits from 2^32 up; anything at or above 2^96 saturates. A root or quotient passes through.
    always_comb
    begin
        case (op_reg)
            OP_MUL:
                result = (acc_reg[ACC_W-1:96] != '0) ? {DATA_W{1'b1}}
                                                     : acc_reg[95:32];
            OP_SQRT:
                result = DATA_W'(root_reg);
            default:
                result = quo_reg;
        endcase
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* sv/running_mean_and_std_dev.sv */
// ----------------------------------------------------------------------------
// Running mean and standard deviation
// Welford update of count, mean and sum of squared deviations per sample;
// emits mean, population deviation and count at the end of each run.
// ----------------------------------------------------------------------------
// A counted sample runs the bit-serial division of the mean step on the shared
// unit and then a multiplication; a skipped one is taken with no arithmetic.
// The last word of a run adds the final 64-step division and the 32-step square
// root unless the count is zero. One word is in work at a time.
// Reset clears the count, mean, sum, skip_missing and the output valid.
// ----------------------------------------------------------------------------
`include "running_mean_and_std_dev_macros.svh"

module running_mean_and_std_dev
    import rmsd_pkg::*;
#(
    parameter int COUNT_BITS  = 24,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_wr_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: sample, zero fill.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // Fields from bit 0: missing.
    input  logic                                 s_axis_tuser,
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: mean[31:0], std_dev[62:32], count[86:63], zero fill.
    output logic [87:0]                          m_axis_tdata,
    // Fields from bit 0: empty_res.
    output logic                                 m_axis_tuser
);

    localparam int MEAN_BITS = SAMPLE_BITS + 16;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIV1_GO   = 4'd1;
    localparam logic [3:0] S_DIV1_WAIT = 4'd2;
    localparam logic [3:0] S_MUL_GO    = 4'd3;
    localparam logic [3:0] S_MUL_WAIT  = 4'd4;
    localparam logic [3:0] S_DIV2_GO   = 4'd5;
    localparam logic [3:0] S_DIV2_WAIT = 4'd6;
    localparam logic [3:0] S_SQRT_GO   = 4'd7;
    localparam logic [3:0] S_SQRT_WAIT = 4'd8;
    localparam logic [3:0] S_EMIT      = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic                  skip_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [MEAN_BITS-1:0]  mean_reg, mean_next;
    logic [DATA_W-1:0]     sum_reg, sum_next;
    logic [MEAN_BITS-1:0]  mag_reg, mag_next;
    logic [DATA_W-1:0]     tmp_reg, tmp_next;
    logic                  up_reg, up_next;
    logic                  last_reg, last_next;

    logic                  m_valid_reg, m_valid_next;
    logic [31:0]           m_mean_reg, m_mean_next;
    logic [30:0]           m_sd_reg, m_sd_next;
    logic [23:0]           m_cnt_reg, m_cnt_next;
    logic                  m_empty_reg, m_empty_next;

    unit_cmd_t             unit_cmd;
    unit_stat_t            unit_stat;
    logic [DATA_W-1:0]     unit_opa;
    logic [DATA_W-1:0]     unit_opb;
    logic [DATA_W-1:0]     unit_res;

    logic                  in_fire;
    logic                  counted;
    logic                  out_load;
    logic [MEAN_BITS-1:0]  x_val;
    logic [MEAN_BITS:0]    diff_w;
    logic [MEAN_BITS:0]    diff_neg;
    logic [MEAN_BITS-1:0]  q_val;
    logic [DATA_W:0]       sum_add;
    logic signed [63:0]    mean_wide;
    logic signed [63:0]    mean_shr;
    logic [31:0]           mean_sat;
    logic [30:0]           sd_sat;

    rmsd_unit u_unit
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (unit_cmd),
        .opa    (unit_opa),
        .opb    (unit_opb),
        .result (unit_res),
        .stat   (unit_stat)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign counted       = !(skip_reg && s_axis_tuser);
    assign out_load      = (state_reg == S_EMIT) && (!m_valid_reg || m_axis_tready);

    assign x_val    = {s_axis_tdata[SAMPLE_BITS-1:0], 16'h0000};
    assign diff_w   = {x_val[MEAN_BITS-1], x_val} - {mean_reg[MEAN_BITS-1], mean_reg};
    assign diff_neg = ~diff_w + 1'b1;
    assign q_val    = unit_res[MEAN_BITS-1:0];
    assign sum_add  = {1'b0, sum_reg} + {1'b0, unit_res};

    always_comb
    begin
        mean_wide = 64'($signed(mean_reg));
        mean_shr  = mean_wide >>> 16;
        if (mean_shr > MEAN_OUT_MAX)
        begin
            mean_sat = MEAN_OUT_MAX[31:0];
        end
        else if (mean_shr < MEAN_OUT_MIN)
        begin
            mean_sat = MEAN_OUT_MIN[31:0];
        end
        else
        begin
            mean_sat = mean_shr[31:0];
        end
        sd_sat = (tmp_reg[DATA_W-1:31] != '0) ? 31'h7FFF_FFFF : tmp_reg[30:0];
    end

    always_comb
    begin
        unit_cmd.start = 1'b0;
        unit_cmd.op    = OP_DIV;
        unit_cmd.steps = STEP_W'(MEAN_BITS);
        unit_opa       = DATA_W'(mag_reg) << (DATA_W - MEAN_BITS);
        unit_opb       = DATA_W'(count_reg);
        case (state_reg)
            S_DIV1_GO:
            begin
                unit_cmd.start = 1'b1;
            end
            S_MUL_GO:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = OP_MUL;
                unit_opa       = DATA_W'(mag_reg);
                unit_opb       = tmp_reg;
            end
            S_DIV2_GO:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.steps = STEP_W'(DATA_W);
                unit_opa       = sum_reg;
            end
            S_SQRT_GO:
            begin
                unit_cmd.start = 1'b1;
                unit_cmd.op    = OP_SQRT;
                unit_opa       = tmp_reg;
            end
            default:
            begin
                unit_cmd.start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        mean_next    = mean_reg;
        sum_next     = sum_reg;
        mag_next     = mag_reg;
        tmp_next     = tmp_reg;
        up_next      = up_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_mean_next  = m_mean_reg;
        m_sd_next    = m_sd_reg;
        m_cnt_next   = m_cnt_reg;
        m_empty_next = m_empty_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = s_axis_tlast;
                    if (counted)
                    begin
                        if (count_reg != {COUNT_BITS{1'b1}})
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        up_next    = !diff_w[MEAN_BITS];
                        mag_next   = diff_w[MEAN_BITS] ? diff_neg[MEAN_BITS-1:0]
                                                       : diff_w[MEAN_BITS-1:0];
                        state_next = S_DIV1_GO;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = (count_reg == '0) ? S_EMIT : S_DIV2_GO;
                    end
                end
            end
            S_DIV1_GO:
            begin
                state_next = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (unit_stat.done)
                begin
                    mean_next  = up_reg ? (mean_reg + q_val) : (mean_reg - q_val);
                    tmp_next   = DATA_W'(mag_reg - q_val);
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (unit_stat.done)
                begin
                    sum_next   = sum_add[DATA_W] ? {DATA_W{1'b1}} : sum_add[DATA_W-1:0];
                    state_next = last_reg ? S_DIV2_GO : S_IDLE;
                end
            end
            S_DIV2_GO:
            begin
                state_next = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (unit_stat.done)
                begin
                    tmp_next   = unit_res;
                    state_next = S_SQRT_GO;
                end
            end
            S_SQRT_GO:
            begin
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (unit_stat.done)
                begin
                    tmp_next   = unit_res;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_empty_next = (count_reg == '0);
                    m_mean_next  = (count_reg == '0) ? 32'h0 : mean_sat;
                    m_sd_next    = (count_reg == '0) ? 31'h0 : sd_sat;
                    m_cnt_next   = 24'(count_reg);
                    count_next   = '0;
                    mean_next    = '0;
                    sum_next     = '0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            skip_reg    <= 1'b0;
            count_reg   <= '0;
            mean_reg    <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            mean_reg    <= mean_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
            begin
                skip_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        tmp_reg     <= tmp_next;
        up_reg      <= up_next;
        last_reg    <= last_next;
        m_mean_reg  <= m_mean_next;
        m_sd_reg    <= m_sd_next;
        m_cnt_reg   <= m_cnt_next;
        m_empty_reg <= m_empty_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_cnt_reg, m_sd_reg, m_mean_reg};
    assign m_axis_tuser  = m_empty_reg;

    `RMSD_ASSERT_SAME(a_start_when_free, unit_cmd.start, !unit_stat.busy,
        "Arithmetic unit started while busy.")
    `RMSD_ASSERT_SAME(a_done_while_waiting, unit_stat.done,
        state_reg == S_DIV1_WAIT || state_reg == S_MUL_WAIT ||
        state_reg == S_DIV2_WAIT || state_reg == S_SQRT_WAIT,
        "Arithmetic unit finished outside a wait state.")
    `RMSD_ASSERT_NEXT(a_emit_clears, out_load,
        count_reg == '0 && sum_reg == '0 && mean_reg == '0 && m_valid_reg,
        "Run state not cleared after a result word.")
    `RMSD_ASSERT_NEXT(a_count_nonzero, in_fire && counted, count_reg != '0,
        "Counted word left the count at zero.")

endmodule
